>>> src/ci64_pkg.sv
// Package: command and status codes, payload types for the checked int64 ALU
`timescale 1ns / 1ps
package ci64_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ADD_OVF = 3'd1,
        ST_SUB_OVF = 3'd2,
        ST_MUL_OVF = 3'd3,
        ST_DIV_ZERO = 3'd4,
        ST_DIV_OVF = 3'd5,
        ST_NEG_OVF = 3'd6
    } t_status;

    localparam int DataW = 64;
    // divider retires this many quotient bits per pipeline stage
    localparam int DivBitsPerStage = 4;
    localparam int DivStages = DataW / DivBitsPerStage;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         status;
    } t_out_item;

    // per-item control carried alongside the datapath
    typedef struct packed {
        logic [2:0]  cmd;
        logic        neg;       // result sign for mul/div
        logic        early;     // result already final (add/sub/neg/err/unused)
        logic [63:0] value;     // early value
        logic [2:0]  status;    // early status
    } t_ctl;

endpackage

>>> src/checked_int64_alu.sv
// Top level: pipelined overflow-checked signed 64-bit ALU
//
// Channel | Signals                   | Payload
// --------+---------------------------+-------------------------
// in      | i_valid / o_ready         | i_item  (cmd, a, b)
// out     | o_valid / i_ready         | o_item  (value, status)
//
// Same depth for every command; one item per cycle while not stalled.
// Depth is set by the restoring divider, 4 quotient bits per stage; the
// 64x64 multiply is split into four 32x32 products summed over two stages.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// A stall on the output freezes the whole pipeline; ready is high whenever
// the output register is empty or being taken.
`timescale 1ns / 1ps
module checked_int64_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ci64_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ci64_pkg::t_out_item o_item
);
    import ci64_pkg::*;

    localparam int NStg = DivStages + 4;

    // global advance: every stage moves when the output can move
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // ---------------- stage 0: decode, early results, magnitudes
    logic [63:0] w_a, w_b, w_ma, w_mb, w_sum, w_dif;
    t_ctl        w_ctl0;
    assign w_a   = i_item.operand_a;
    assign w_b   = i_item.operand_b;
    assign w_ma  = w_a[63] ? (64'd0 - w_a) : w_a;
    assign w_mb  = w_b[63] ? (64'd0 - w_b) : w_b;
    assign w_sum = w_a + w_b;
    assign w_dif = w_a - w_b;

    always_comb begin
        w_ctl0        = '0;
        w_ctl0.cmd    = i_item.cmd;
        w_ctl0.neg    = w_a[63] ^ w_b[63];
        w_ctl0.early  = 1'b1;
        unique case (i_item.cmd)
            CMD_ADD: begin
                if (!(w_a[63] ^ w_b[63]) && (w_sum[63] ^ w_a[63]))
                    w_ctl0.status = ST_ADD_OVF;
                else
                    w_ctl0.value = w_sum;
            end
            CMD_SUB: begin
                if ((w_a[63] ^ w_b[63]) && (w_dif[63] ^ w_a[63]))
                    w_ctl0.status = ST_SUB_OVF;
                else
                    w_ctl0.value = w_dif;
            end
            CMD_MUL: w_ctl0.early = 1'b0;
            CMD_DIV: begin
                if (w_b == 64'd0)
                    w_ctl0.status = ST_DIV_ZERO;
                else if (w_a == {1'b1, 63'd0} && w_b == '1)
                    w_ctl0.status = ST_DIV_OVF;
                else
                    w_ctl0.early = 1'b0;
            end
            CMD_NEG: begin
                if (w_b == {1'b1, 63'd0})
                    w_ctl0.status = ST_NEG_OVF;
                else
                    w_ctl0.value = 64'd0 - w_b;
            end
            default: ;
        endcase
    end

    // pipeline registers
    logic [NStg-1:0] r_vld;
    t_ctl            r_ctl [NStg];
    logic [63:0]     r_ma  [NStg];   // divider: remaining dividend bits
    logic [63:0]     r_mb  [NStg];   // divisor magnitude
    logic [63:0]     r_rem [NStg];   // partial remainder
    logic [63:0]     r_q   [NStg];   // quotient / mul low
    logic [63:0]     r_p00, r_p01, r_p10, r_p11;
    logic            r_mz;           // mul operand zero
    t_out_item       r_out;

    // valid bits shift with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld   <= {r_vld[NStg-2:0], i_valid};
            o_valid <= r_vld[NStg-1];
        end
    end

    // divider step: DivBitsPerStage restoring iterations
    function automatic logic [191:0] f_div_step(input logic [63:0] rem,
                                                input logic [63:0] dvd,
                                                input logic [63:0] q,
                                                input logic [63:0] dvs);
        logic [64:0] t;
        logic [63:0] rr, dd, qq;
        rr = rem; dd = dvd; qq = q;
        for (int k = 0; k < DivBitsPerStage; k++) begin
            t  = {rr, dd[63]};
            dd = {dd[62:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t  = t - {1'b0, dvs};
                qq = {qq[62:0], 1'b1};
            end else begin
                qq = {qq[62:0], 1'b0};
            end
            rr = t[63:0];
        end
        return {rr, dd, qq};
    endfunction

    logic [127:0] w_mid;
    always_comb begin
        w_mid = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
              + {r_p11, 64'd0};
    end

    // stage 2 control: multiply result and overflow check
    t_ctl w_ctl2;
    always_comb begin
        w_ctl2 = r_ctl[1];
        if (r_ctl[1].cmd == CMD_MUL) begin
            w_ctl2.early  = 1'b1;
            w_ctl2.value  = '0;
            w_ctl2.status = ST_OK;
            // a zero operand always gives zero
            if (!r_mz) begin
                if (w_mid[127:64] != 64'd0 ||
                    (r_ctl[1].neg ? (w_mid[63:0] > {1'b1, 63'd0}) : w_mid[63]))
                    w_ctl2.status = ST_MUL_OVF;
                else
                    w_ctl2.value = r_ctl[1].neg ? (64'd0 - w_mid[63:0])
                                                : w_mid[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 0 -> reg 0
            r_ctl[0] <= w_ctl0;
            r_ma[0]  <= w_ma;
            r_mb[0]  <= w_mb;
            // stage 1: four 32x32 partial products (mul only uses them)
            r_ctl[1] <= r_ctl[0];
            r_ma[1]  <= r_ma[0];
            r_mb[1]  <= r_mb[0];
            r_p00    <= r_ma[0][31:0]  * r_mb[0][31:0];
            r_p01    <= r_ma[0][31:0]  * r_mb[0][63:32];
            r_p10    <= r_ma[0][63:32] * r_mb[0][31:0];
            r_p11    <= r_ma[0][63:32] * r_mb[0][63:32];
            r_mz     <= (r_ma[0] == 64'd0) || (r_mb[0] == 64'd0);
            // stage 2: sum products; seed divider
            r_ctl[2] <= w_ctl2;
            r_ma[2]  <= r_ma[1];
            r_mb[2]  <= r_mb[1];
            r_rem[2] <= '0;
            r_q[2]   <= w_mid[63:0];
            // divider stages
            for (int s = 3; s < NStg - 1; s++) begin
                r_ctl[s] <= r_ctl[s-1];
                r_mb[s]  <= r_mb[s-1];
                {r_rem[s], r_ma[s], r_q[s]} <=
                    f_div_step(r_rem[s-1], r_ma[s-1], r_q[s-1], r_mb[s-1]);
            end
            // final: sign fix and select
            r_ctl[NStg-1] <= r_ctl[NStg-2];
            r_q[NStg-1]   <= r_ctl[NStg-2].neg ? (64'd0 - r_q[NStg-2])
                                               : r_q[NStg-2];
            if (r_ctl[NStg-1].early) begin
                r_out.value  <= r_ctl[NStg-1].value;
                r_out.status <= r_ctl[NStg-1].status;
            end else begin
                r_out.value  <= r_q[NStg-1];
                r_out.status <= ST_OK;
            end
        end
    end

    assign o_item = r_out;

`ifndef SYNTHESIS
    // a stalled output holds its result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output changed under stall");
    // error status always carries zero value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != ST_OK |-> o_item.value == 64'd0)
        else $error("nonzero value with error status");
    // status code in range
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.status <= ST_NEG_OVF)
        else $error("bad status code");
    // ready follows output state
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
`endif

endmodule

>>> test/tb_checked_int64_alu.sv
// Testbench: checked int64 ALU, scoreboard class with directed and random transfers
`timescale 1ns / 1ps
module tb_checked_int64_alu;
    import ci64_pkg::*;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int RandCount = 1050;
    localparam int CycleLimit = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int err_count;
    int cycle_count;

    task report_err(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Predicts one result per input transfer and checks them in order
    class alu_scoreboard;
        t_out_item pending[$];

        function logic [63:0] mag(logic [63:0] x);
            return x[63] ? -x : x;
        endfunction

        function t_out_item compute(t_in_item it);
            t_out_item r;
            logic [63:0]  a;
            logic [63:0]  b;
            logic [63:0]  s;
            logic [127:0] p;
            logic [63:0]  q;
            logic         neg;
            a = it.operand_a;
            b = it.operand_b;
            neg = a[63] ^ b[63];
            r.value = '0;
            r.status = ST_OK;
            case (it.cmd)
                CMD_ADD: begin
                    s = a + b;
                    if (a[63] == b[63] && s[63] != a[63]) r.status = ST_ADD_OVF;
                    else r.value = s;
                end
                CMD_SUB: begin
                    s = a - b;
                    if (a[63] != b[63] && s[63] != a[63]) r.status = ST_SUB_OVF;
                    else r.value = s;
                end
                CMD_MUL: begin
                    p = {64'd0, mag(a)} * {64'd0, mag(b)};
                    if (p == '0) r.value = '0;
                    else if (p[127:64] != '0 ||
                             (neg ? (p[63:0] > MinVal) : (p[63:0] >= MinVal)))
                        r.status = ST_MUL_OVF;
                    else r.value = neg ? -p[63:0] : p[63:0];
                end
                CMD_DIV: begin
                    if (b == '0) r.status = ST_DIV_ZERO;
                    else if (a == MinVal && b == '1) r.status = ST_DIV_OVF;
                    else begin
                        q = mag(a) / mag(b);
                        r.value = neg ? -q : q;
                    end
                end
                CMD_NEG: begin
                    if (b == MinVal) r.status = ST_NEG_OVF;
                    else r.value = -b;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(t_in_item it);
            pending = {pending, compute(it)};
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report_err($sformatf("unexpected result value=%h status=%0d",
                                     got.value, got.status));
            end else begin
                want = pending.pop_front();
                if (got.value !== want.value)
                    report_err($sformatf("value got %h want %h", got.value, want.value));
                if (got.status !== want.status)
                    report_err($sformatf("status got %0d want %0d",
                                         got.status, want.status));
            end
        endtask
    endclass

    alu_scoreboard sb;

    checked_int64_alu u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Operand mix: corners, small values, half-range and full-range
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0: return MinVal;
                    1: return MaxVal;
                    2: return '0;
                    3: return 64'd1;
                    4: return '1;
                    default: return MinVal + 64'd1;
                endcase
            end
            1: return 64'($signed($urandom_range(0, 200)) - 100);
            2: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // valid stays high after a transfer unless an idle gap follows
    task send_item(t_in_item it);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
    endtask

    task send_op(logic [2:0] cmd, logic [63:0] a, logic [63:0] b);
        t_in_item it;
        it.cmd = cmd;
        it.operand_a = a;
        it.operand_b = b;
        send_item(it);
    endtask

    // Receiver: random stall per transfer, with stall-free stretches
    initial begin
        int gap;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (cycle_count % 4000 < 600) gap = 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_item);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_checked_int64_alu: errors");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int drain;
        sb = new();
        err_count = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners and each flagged case
        send_op(CMD_ADD, MaxVal, 64'd1);
        send_op(CMD_ADD, MinVal, '1);
        send_op(CMD_ADD, MaxVal, MinVal);
        send_op(CMD_SUB, MinVal, 64'd1);
        send_op(CMD_SUB, MaxVal, '1);
        send_op(CMD_SUB, '0, MinVal);
        send_op(CMD_MUL, MinVal, '0);
        send_op(CMD_MUL, '0, MinVal);
        send_op(CMD_MUL, MinVal, 64'd1);
        send_op(CMD_MUL, MinVal, '1);
        send_op(CMD_MUL, 64'h1_0000_0000, 64'h8000_0000);
        send_op(CMD_MUL, 64'h1_0000_0000, 64'hFFFF_FFFF_8000_0000);
        send_op(CMD_MUL, MaxVal, MaxVal);
        send_op(CMD_DIV, MaxVal, '0);
        send_op(CMD_DIV, MinVal, '0);
        send_op(CMD_DIV, MinVal, '1);
        send_op(CMD_DIV, MinVal, 64'd1);
        send_op(CMD_DIV, -64'sd7, 64'd2);
        send_op(CMD_DIV, MaxVal, MinVal);
        send_op(CMD_NEG, MaxVal, MinVal);
        send_op(CMD_NEG, '1, MaxVal);
        send_op(CMD_NEG, '0, '0);
        send_op(3'd5, MaxVal, MaxVal);
        send_op(3'd6, '1, '1);
        send_op(3'd7, MinVal, MinVal);

        // Random transfers; sender holds off once until all results are back
        for (int i = 0; i < RandCount; i++) begin
            if (i == RandCount / 2) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending.size() != 0);
            end
            it.cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
            it.operand_a = pick_operand();
            it.operand_b = pick_operand();
            if (i % 16 < 4) begin
                // back-to-back burst
                in_valid <= 1'b1;
                in_item  <= it;
                do @(posedge clk); while (!in_ready);
                sb.note_input(it);
            end else begin
                send_item(it);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        for (drain = 0; drain < 40; drain++) @(posedge clk);
        if (err_count == 0 && sb.pending.size() == 0) begin
            $display("tb_checked_int64_alu: clean");
        end else begin
            $display("tb_checked_int64_alu: errors");
        end
        $finish;
    end
endmodule
